@@ sv/pot_smoothing_soft_takeover_assert.svh @@
// Assertion macros used by the top-level RTL file
`ifndef POT_SMOOTHING_SOFT_TAKEOVER_ASSERT_SVH
`define POT_SMOOTHING_SOFT_TAKEOVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pot_smoothing_soft_takeover: assertion failed");
`define PST_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pot_smoothing_soft_takeover: assertion failed");
`else
`define PST_ASSERT(label, clk, rst_n, prop)
`define PST_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ sv/pst_pkg.sv @@
`default_nettype none

package pst_pkg;

  localparam int unsigned POT_COUNT_DEF = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned UNLOCK_MIN = 2;
  localparam int unsigned UNLOCK_MAX = 253;

  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_EDIT   = 2'd1;
  localparam logic [1:0] MODE_PRESET = 2'd2;

  typedef enum logic [1:0] {
    CMD_POT  = 2'd0,
    CMD_VOL  = 2'd1,
    CMD_LOCK = 2'd2,
    CMD_MODE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_POT  = 3'd0,
    OP_VOL  = 3'd1,
    OP_LOCK = 3'd2,
    OP_MODE = 3'd3,
    OP_NOP  = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
    logic [9:0] sample;
    logic [7:0] lock_level;
    logic [1:0] new_mode;
  } item_t;

  typedef struct packed {
    logic [4:0] channel;
    logic [9:0] level;
    logic       patch_write;
    logic       unlocked_now;
    logic [1:0] mode_now;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

@@ sv/pst_front.sv @@
`default_nettype none

module pst_front import pst_pkg::*; #(
  parameter int unsigned POT_COUNT = POT_COUNT_DEF
) (
  input  wire logic [1:0]  command_i,
  input  wire logic [4:0]  pot_index_i,
  input  wire logic [9:0]  sample_i,
  input  wire logic [7:0]  lock_level_i,
  input  wire logic [1:0]  new_mode_i,
  output item_t            item_o
);

  logic in_range;

  assign in_range = 32'(pot_index_i) < POT_COUNT;

  always_comb begin
    item_o.idx        = 5'd0;
    item_o.sample     = sample_i;
    item_o.lock_level = lock_level_i;
    item_o.new_mode   = new_mode_i;
    item_o.op         = OP_NOP;
    case (cmd_e'(command_i))
      CMD_POT: begin
        item_o.idx = pot_index_i;
        item_o.op  = in_range ? OP_POT : OP_NOP;
      end
      CMD_VOL: begin
        item_o.op = OP_VOL;
      end
      CMD_LOCK: begin
        item_o.idx = pot_index_i;
        item_o.op  = in_range ? OP_LOCK : OP_NOP;
      end
      CMD_MODE: begin
        item_o.op = (new_mode_i <= MODE_PRESET) ? OP_MODE : OP_NOP;
      end
      default: begin
        item_o.op = OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/pst_queue.sv @@
`default_nettype none

module pst_queue import pst_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  item_t        push_item_i,
  input  wire logic    pop_i,
  output item_t        pop_item_o,
  output queue_status_t status_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (32'(p) == QUEUE_DEPTH - 1) r = '0;
    else                            r = p + PTR_W'(1);
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + CNT_W'(1);
    if (pop_i && !push_i) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign pop_item_o     = mem_q[rd_ptr_q];
  assign status_o.full  = 32'(count_q) == QUEUE_DEPTH;
  assign status_o.empty = count_q == '0;

endmodule

`default_nettype wire

@@ sv/pst_back.sv @@
`default_nettype none

module pst_back import pst_pkg::*; #(
  parameter int unsigned POT_COUNT = POT_COUNT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic item_valid_i,
  input  item_t     item_i,
  output logic      pop_o,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output result_t   res_o
);

  localparam int unsigned IDX_W = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1;

  logic [9:0] pot_level_q    [POT_COUNT];
  logic       pot_locked_q   [POT_COUNT];
  logic [7:0] locked_level_q [POT_COUNT];
  logic [1:0] mode_q, mode_d;
  logic [9:0] volume_q, volume_d;
  logic       res_valid_q;
  result_t    res_q, res_d;

  logic [IDX_W-1:0] addr;
  logic [9:0]       smoothed;
  logic [7:0]       delta;
  logic             unlock_hit;
  logic             clear_lock;

  function automatic logic [9:0] smooth(logic [9:0] level, logic [9:0] raw);
    logic signed [11:0] diff;
    logic signed [11:0] step;
    logic signed [11:0] sum;
    diff = $signed({2'b00, raw}) - $signed({2'b00, level});
    step = diff >>> 2;
    sum  = $signed({2'b00, level}) + step;
    return sum[9:0];
  endfunction

  assign addr       = IDX_W'(item_i.idx);
  assign smoothed   = smooth(pot_level_q[addr], item_i.sample);
  assign delta      = locked_level_q[addr] - smoothed[9:2];
  assign unlock_hit = (delta > 8'(UNLOCK_MIN)) && (delta < 8'(UNLOCK_MAX));
  assign pop_o      = item_valid_i && (!res_valid_q || res_ready_i);

  always_comb begin
    mode_d     = mode_q;
    volume_d   = volume_q;
    clear_lock = 1'b0;
    res_d              = '0;
    res_d.channel      = item_i.idx;
    case (item_i.op)
      OP_POT: begin
        res_d.level = smoothed;
        if (mode_q == MODE_MANUAL || !pot_locked_q[addr]) begin
          res_d.patch_write = 1'b1;
        end else if (unlock_hit) begin
          res_d.patch_write  = 1'b1;
          res_d.unlocked_now = 1'b1;
          clear_lock         = 1'b1;
          mode_d             = MODE_EDIT;
        end
      end
      OP_VOL: begin
        volume_d    = smooth(volume_q, item_i.sample);
        res_d.level = volume_d;
      end
      OP_LOCK: begin
        res_d.level = pot_level_q[addr];
      end
      OP_MODE: begin
        mode_d = item_i.new_mode;
      end
      default: begin
        res_d.level = '0;
      end
    endcase
    res_d.mode_now = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POT_COUNT; i++) begin
        pot_level_q[i]    <= '0;
        pot_locked_q[i]   <= 1'b0;
        locked_level_q[i] <= '0;
      end
      mode_q      <= MODE_MANUAL;
      volume_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q      <= mode_d;
        volume_q    <= volume_d;
        res_valid_q <= 1'b1;
        if (item_i.op == OP_POT) begin
          pot_level_q[addr] <= smoothed;
          if (clear_lock) pot_locked_q[addr] <= 1'b0;
        end
        if (item_i.op == OP_LOCK) begin
          pot_locked_q[addr]   <= 1'b1;
          locked_level_q[addr] <= item_i.lock_level;
        end
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ sv/pot_smoothing_soft_takeover.sv @@
// Panel potentiometer conditioning with smoothing and soft takeover.
// Input stream: one command per transfer (tuser), operands in tdata.
//   Parameter-pot samples smooth the pot level by a quarter step and write
//   it to the patch unless the pot is locked outside manual mode; a locked
//   pot releases once its level / 4 is 3 or more below or 4 or more above the
//   locked level, and switches to edit. Volume samples smooth the volume
//   level; lock and set-mode commands load pot lock state and the patch mode.
// Output stream: exactly one result transfer per input transfer, in order.
// Path: each item is registered in a queue entry, then its result in the
// output register; throughput one item per cycle while the receiver takes
// results, set by the read-modify-write of the per-pot state in the back end.
// A two-entry queue sits between decode and execution; when the receiver
// stalls the result register holds, the queue fills and tready drops while
// two transfers wait in it. No item is lost or repeated.
// Reset clears all pot levels, locks, locked levels, the volume level and
// sets manual mode; tready is high during and after reset, as the queue is empty.
`default_nettype none

`include "pot_smoothing_soft_takeover_assert.svh"

module pot_smoothing_soft_takeover import pst_pkg::*; #(
  parameter int unsigned POT_COUNT = POT_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [4:0] pot_index, [14:5] sample, [22:15] lock_level, [24:23] new_mode
  input  wire logic [31:0] s_axis_tdata_i,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [4:0] channel, [14:5] level, [15] patch_write, [16] unlocked_now,
  // [18:17] mode_now
  output logic [23:0]      m_axis_tdata_o
);

  item_t         front_item;
  item_t         queue_item;
  queue_status_t queue_status;
  logic          push;
  logic          pop;
  result_t       res;

  pst_front #(
    .POT_COUNT (POT_COUNT)
  ) u_front (
    .command_i    (s_axis_tuser_i),
    .pot_index_i  (s_axis_tdata_i[4:0]),
    .sample_i     (s_axis_tdata_i[14:5]),
    .lock_level_i (s_axis_tdata_i[22:15]),
    .new_mode_i   (s_axis_tdata_i[24:23]),
    .item_o       (front_item)
  );

  assign s_axis_tready_o = !queue_status.full;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;

  pst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .pop_i       (pop),
    .pop_item_o  (queue_item),
    .status_o    (queue_status)
  );

  pst_back #(
    .POT_COUNT (POT_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!queue_status.empty),
    .item_i       (queue_item),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tdata_o = {5'd0, res.mode_now, res.unlocked_now, res.patch_write,
                           res.level, res.channel};

  `PST_ASSERT(a_unlock_sets_edit, clk_i, rst_ni,
    m_axis_tvalid_o && res.unlocked_now |-> res.patch_write && res.mode_now == MODE_EDIT)
  `PST_ASSERT(a_accept_fills_queue, clk_i, rst_ni,
    push |=> !queue_status.empty)
  `PST_ASSERT(a_queue_drains_to_output, clk_i, rst_ni,
    !queue_status.empty && !m_axis_tvalid_o |=> m_axis_tvalid_o)
  `PST_ASSERT_ALWAYS(a_reset_clears_output, clk_i,
    !rst_ni |-> !m_axis_tvalid_o && queue_status.empty)

endmodule

`default_nettype wire

@@ tb/pot_smoothing_soft_takeover_test.sv @@
`timescale 1ns / 1ps

module pot_smoothing_soft_takeover_test;
  import pst_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] idx;
    logic [9:0] sample;
    logic [7:0] lock_level;
    logic [1:0] new_mode;
  } pot_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = CMD_POT;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  pot_smoothing_soft_takeover dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pot_cmd_t   pending_cmds[$];
  result_t    expected_results[$];
  pot_cmd_t   drive_cmd;

  logic [9:0] pot_lvl[POT_COUNT_DEF];
  logic       pot_is_locked[POT_COUNT_DEF];
  logic [7:0] pot_lock_lvl[POT_COUNT_DEF];
  logic [1:0] cur_mode;
  logic [9:0] vol_lvl;

  int errors = 0;
  int accepted_items = 0;
  int cmd_count[4] = '{0, 0, 0, 0};
  int writes_seen = 0;
  int releases_seen = 0;
  int send_gap = 0;
  int send_burst = 0;
  int recv_stall = 0;
  int recv_burst = 0;
  int hold_left = 0;
  int holds_done = 0;

  initial begin
    for (int i = 0; i < POT_COUNT_DEF; i++) begin
      pot_lvl[i] = '0;
      pot_is_locked[i] = 1'b0;
      pot_lock_lvl[i] = '0;
    end
    cur_mode = MODE_MANUAL;
    vol_lvl = '0;
  end

  function automatic logic [9:0] smooth_toward(logic [9:0] cur, logic [9:0] raw);
    int d;
    d = int'(raw) - int'(cur);
    return 10'(int'(cur) + (d >>> 2));
  endfunction

  function automatic result_t apply_pot_command(pot_cmd_t c);
    result_t    r;
    logic [9:0] v;
    logic [7:0] delta;
    r = '0;
    case (c.cmd)
      CMD_POT: begin
        r.channel = c.idx;
        if (int'(c.idx) < POT_COUNT_DEF) begin
          v = smooth_toward(pot_lvl[c.idx], c.sample);
          pot_lvl[c.idx] = v;
          r.level = v;
          delta = 8'(int'(pot_lock_lvl[c.idx]) - int'(v >> 2));
          if (cur_mode == MODE_MANUAL || !pot_is_locked[c.idx]) begin
            r.patch_write = 1'b1;
          end else if (delta > UNLOCK_MIN && delta < UNLOCK_MAX) begin
            r.patch_write = 1'b1;
            r.unlocked_now = 1'b1;
            pot_is_locked[c.idx] = 1'b0;
            cur_mode = MODE_EDIT;
          end
        end
      end
      CMD_VOL: begin
        vol_lvl = smooth_toward(vol_lvl, c.sample);
        r.level = vol_lvl;
      end
      CMD_LOCK: begin
        r.channel = c.idx;
        if (int'(c.idx) < POT_COUNT_DEF) begin
          pot_is_locked[c.idx] = 1'b1;
          pot_lock_lvl[c.idx] = c.lock_level;
          r.level = pot_lvl[c.idx];
        end
      end
      default: begin
        if (c.new_mode != MODE_UNUSED) cur_mode = c.new_mode;
      end
    endcase
    r.mode_now = cur_mode;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int clamp10(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  task automatic queue_cmd(cmd_e cmd, int idx, int smp, int lvl, int nm);
    pot_cmd_t c;
    c.cmd = cmd;
    c.idx = 5'(idx);
    c.sample = 10'(smp);
    c.lock_level = 8'(lvl);
    c.new_mode = 2'(nm);
    pending_cmds.push_back(c);
  endtask

  task automatic report_mismatch(string what, int got_v, int exp_v);
    $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got_v, exp_v);
    errors++;
  endtask

  // sender: offer queued commands with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= CMD_POT;
      send_gap        <= 0;
      send_burst      <= 0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (send_gap != 0) begin
        send_gap        <= send_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        drive_cmd = pending_cmds.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {7'b0, drive_cmd.new_mode, drive_cmd.lock_level,
                            drive_cmd.sample, drive_cmd.idx};
        s_axis_tuser_i  <= drive_cmd.cmd;
        if (send_burst != 0) begin
          send_burst <= send_burst - 1;
          send_gap   <= 0;
        end else begin
          send_gap <= pick_gap();
          if ($urandom_range(0, 39) == 0) send_burst <= $urandom_range(20, 60);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block fills up and drops tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && accepted_items >= 400) ||
                 (holds_done == 1 && accepted_items >= 1000)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // receiver: random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_stall      <= 0;
      recv_burst      <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall      <= recv_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (recv_burst != 0) recv_burst <= recv_burst - 1;
      else if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap();
      else if ($urandom_range(0, 39) == 0) recv_burst <= $urandom_range(20, 60);
    end
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    pot_cmd_t c;
    result_t  got;
    result_t  want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        c.cmd        = cmd_e'(s_axis_tuser_i);
        c.idx        = s_axis_tdata_i[4:0];
        c.sample     = s_axis_tdata_i[14:5];
        c.lock_level = s_axis_tdata_i[22:15];
        c.new_mode   = s_axis_tdata_i[24:23];
        expected_results.push_back(apply_pot_command(c));
        cmd_count[s_axis_tuser_i] <= cmd_count[s_axis_tuser_i] + 1;
        accepted_items <= accepted_items + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.channel      = m_axis_tdata_o[4:0];
        got.level        = m_axis_tdata_o[14:5];
        got.patch_write  = m_axis_tdata_o[15];
        got.unlocked_now = m_axis_tdata_o[16];
        got.mode_now     = m_axis_tdata_o[18:17];
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, level", got.level, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.channel != want.channel)
            report_mismatch("channel", got.channel, want.channel);
          if (got.level != want.level)
            report_mismatch("level", got.level, want.level);
          if (got.patch_write != want.patch_write)
            report_mismatch("patch_write", got.patch_write, want.patch_write);
          if (got.unlocked_now != want.unlocked_now)
            report_mismatch("unlocked_now", got.unlocked_now, want.unlocked_now);
          if (got.mode_now != want.mode_now)
            report_mismatch("mode_now", got.mode_now, want.mode_now);
          if (want.patch_write) writes_seen <= writes_seen + 1;
          if (want.unlocked_now) releases_seen <= releases_seen + 1;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int p;
    int lvl;
    int target;
    int n;
    int r;

    rst_ni <= 1'b0;

    queue_cmd(CMD_POT, 0, 1023, 0, 0);
    queue_cmd(CMD_POT, 31, 1023, 255, 3);
    queue_cmd(CMD_POT, 31, 0, 0, 0);
    queue_cmd(CMD_VOL, 0, 1023, 0, 0);
    queue_cmd(CMD_VOL, 31, 0, 255, 3);
    queue_cmd(CMD_VOL, 0, 1023, 0, 0);
    queue_cmd(CMD_LOCK, 0, 1023, 255, 3);
    queue_cmd(CMD_LOCK, 31, 0, 0, 0);
    queue_cmd(CMD_MODE, 31, 1023, 255, MODE_PRESET);
    queue_cmd(CMD_MODE, 0, 0, 0, MODE_UNUSED);
    queue_cmd(CMD_POT, 0, 1023, 0, 0);
    queue_cmd(CMD_LOCK, 5, 0, 0, 0);
    queue_cmd(CMD_LOCK, 5, 0, 2, 0);
    queue_cmd(CMD_MODE, 0, 0, 0, MODE_PRESET);
    queue_cmd(CMD_POT, 5, 0, 0, 0);
    queue_cmd(CMD_POT, 5, 40, 0, 0);
    queue_cmd(CMD_POT, 5, 60, 0, 0);
    queue_cmd(CMD_POT, 5, 60, 0, 0);
    queue_cmd(CMD_LOCK, 5, 0, 0, 0);
    queue_cmd(CMD_POT, 5, 60, 0, 0);
    queue_cmd(CMD_MODE, 0, 0, 0, MODE_MANUAL);
    queue_cmd(CMD_POT, 31, 682, 0, 0);
    queue_cmd(CMD_MODE, 0, 0, 0, MODE_EDIT);
    queue_cmd(CMD_POT, 31, 341, 0, 0);
    queue_cmd(CMD_MODE, 31, 1023, 255, MODE_EDIT);

    // mostly warm-up, lock and move sequences; the rest random noise
    n = pending_cmds.size();
    while (pending_cmds.size() < n + RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        p = $urandom_range(0, POT_COUNT_DEF - 1);
        target = $urandom_range(0, 1023);
        repeat ($urandom_range(2, 12))
          queue_cmd(CMD_POT, p, clamp10(target + $urandom_range(0, 6) - 3),
                    $urandom_range(0, 255), $urandom_range(0, 3));
        lvl = (target >> 2) + $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 4) == 0) lvl = $urandom_range(0, 255);
        queue_cmd(CMD_LOCK, p, $urandom_range(0, 1023), lvl & 255, $urandom_range(0, 3));
        r = $urandom_range(0, 5);
        if (r < 3) queue_cmd(CMD_MODE, p, $urandom_range(0, 1023), $urandom_range(0, 255),
                             MODE_PRESET);
        else if (r == 3) queue_cmd(CMD_MODE, p, $urandom_range(0, 1023),
                                   $urandom_range(0, 255), $urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) target = $urandom_range(0, 1023);
        repeat ($urandom_range(3, 12)) begin
          target = clamp10(target + $urandom_range(0, 24) - 12);
          if ($urandom_range(0, 5) == 0)
            queue_cmd(CMD_VOL, $urandom_range(0, 31), $urandom_range(0, 1023),
                      $urandom_range(0, 255), $urandom_range(0, 3));
          queue_cmd(CMD_POT, p, target, $urandom_range(0, 255), $urandom_range(0, 3));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          queue_cmd(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 31),
                    $urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 3));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Run covered %0d transfers: %0d pot samples, %0d volume samples, %0d locks, %0d mode",
             accepted_items, cmd_count[CMD_POT], cmd_count[CMD_VOL], cmd_count[CMD_LOCK],
             cmd_count[CMD_MODE]);
    $display("%0d patch writes, %0d lock releases, %0d receiver hold-offs, %0d mismatches",
             writes_seen, releases_seen, holds_done, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/pst_pkg.sv
sv/pst_front.sv
sv/pst_queue.sv
sv/pst_back.sv
sv/pot_smoothing_soft_takeover.sv
tb/pot_smoothing_soft_takeover_test.sv
